// ===== design/two_class_multi_queue_core_defines.svh =====
// Assertion macros used by the core design file.
`ifndef TWO_CLASS_MULTI_QUEUE_CORE_DEFINES_SVH
`define TWO_CLASS_MULTI_QUEUE_CORE_DEFINES_SVH

// Check prop on every rising edge outside reset.
`define TCMQ_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check prop on every rising edge, reset included.
`define TCMQ_ASSERT_ALL(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/tcmq_pkg.sv =====
`timescale 1ns / 1ps

package tcmq_pkg;

    localparam int NUM_QUEUES  = 32;
    localparam int QUEUE_DEPTH = 8;
    localparam int TAG_BITS    = 16;

    localparam int QID_W  = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int LEN_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int SLOTS  = NUM_QUEUES * QUEUE_DEPTH;
    localparam int ADDR_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int ENTRY_W = TAG_BITS + 1;

    typedef enum logic [1:0] {
        KIND_ADD  = 2'd0,
        KIND_TAKE = 2'd1,
        KIND_LIST = 2'd2,
        KIND_NONE = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        RC_ADDED      = 3'd0,
        RC_FULL       = 3'd1,
        RC_SERVED     = 3'd2,
        RC_EMPTY      = 3'd3,
        RC_LIST_ENTRY = 3'd4,
        RC_LIST_EMPTY = 3'd5
    } t_rcode;

    typedef struct packed {
        logic [1:0]  kind;
        logic [4:0]  queue_id;
        logic [15:0] tag;
        logic        urgent;
    } t_req;

    typedef struct packed {
        logic [2:0]  result_code;
        logic [15:0] out_tag;
        logic        out_urgent;
        logic [3:0]  queue_count;
        logic        last;
    } t_result;

endpackage

// ===== design/tcmq_ram.sv =====
`timescale 1ns / 1ps

module tcmq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/two_class_multi_queue_core.sv =====
`timescale 1ns / 1ps
// Channel   Handshake            Payload
// request   start / busy         i_req    (t_req)
// result    o_valid, one cycle   o_result (t_result)
//
// Add: the request is registered, then S_EXEC issues the result; take:
// S_EXEC, then S_TAKE; list: S_EXEC, then S_LIST at one entry per cycle,
// read from the entry RAM (one read per cycle, registered) by the FSM.
// Synchronous active-low reset clears all queue lengths and head pointers.
// busy stays high until the last result of a request is issued; the
// receiver cannot stall, so each result shows for exactly one cycle.

`include "two_class_multi_queue_core_defines.svh"

module two_class_multi_queue_core import tcmq_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    output logic    busy,
    input  t_req    i_req,
    output logic    o_valid,
    output t_result o_result
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_TAKE,
        S_LIST
    } t_state;

    t_state              r_state;
    t_req                r_req;
    logic [LEN_W-1:0]    r_len  [NUM_QUEUES];
    logic [PTR_W-1:0]    r_head [NUM_QUEUES];
    logic [LEN_W-1:0]    r_cnt;
    logic [LEN_W-1:0]    r_idx;
    logic [PTR_W-1:0]    r_slot;
    logic                r_valid;
    t_result             r_result;

    logic [QID_W-1:0]    qi;
    logic                q_ok;
    logic [LEN_W-1:0]    cur_len;
    logic [PTR_W-1:0]    cur_head;
    logic                full;
    logic [PTR_W:0]      tail_sum;
    logic [PTR_W-1:0]    tail_slot;
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [ENTRY_W-1:0]  ram_wdata;
    logic [ENTRY_W-1:0]  ram_rdata;
    logic                list_last;

    function automatic logic [PTR_W-1:0] slot_inc(input logic [PTR_W-1:0] p);
        return (32'(p) == QUEUE_DEPTH - 1) ? '0 : PTR_W'(p + 1'b1);
    endfunction

    function automatic logic [PTR_W-1:0] slot_dec(input logic [PTR_W-1:0] p);
        return (p == '0) ? PTR_W'(QUEUE_DEPTH - 1) : PTR_W'(p - 1'b1);
    endfunction

    function automatic logic [ADDR_W-1:0] addr_of(input logic [QID_W-1:0] q,
                                                  input logic [PTR_W-1:0] s);
        return ADDR_W'(ADDR_W'(q) * ADDR_W'(QUEUE_DEPTH)) + ADDR_W'(s);
    endfunction

    assign busy = (r_state != S_IDLE);

    always_comb begin
        qi        = QID_W'(r_req.queue_id);
        q_ok      = 32'(r_req.queue_id) < NUM_QUEUES;
        cur_len   = r_len[qi];
        cur_head  = r_head[qi];
        full      = 32'(cur_len) >= QUEUE_DEPTH;
        tail_sum  = (PTR_W + 1)'(cur_head) + (PTR_W + 1)'(cur_len);
        tail_slot = (32'(tail_sum) >= QUEUE_DEPTH) ?
                    PTR_W'(tail_sum - (PTR_W + 1)'(QUEUE_DEPTH)) : PTR_W'(tail_sum);
        ram_we    = (r_state == S_EXEC) && (r_req.kind == KIND_ADD) && q_ok && !full;
        ram_waddr = addr_of(qi, r_req.urgent ? slot_dec(cur_head) : tail_slot);
        ram_wdata = {r_req.urgent, TAG_BITS'(r_req.tag)};
        ram_raddr = (r_state == S_LIST) ? addr_of(qi, slot_inc(r_slot))
                                        : addr_of(qi, cur_head);
        list_last = (r_idx + LEN_W'(1)) == r_cnt;
    end

    tcmq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOTS)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            for (int i = 0; i < NUM_QUEUES; i++) begin
                r_len[i]  <= '0;
                r_head[i] <= '0;
            end
        end else begin
            r_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_req   <= i_req;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_state              <= S_IDLE;
                    r_result.out_tag     <= '0;
                    r_result.out_urgent  <= 1'b0;
                    r_result.last        <= 1'b1;
                    r_result.queue_count <= 4'(cur_len);
                    r_cnt                <= cur_len;
                    r_idx                <= '0;
                    r_slot               <= cur_head;
                    if (r_req.kind != KIND_NONE) begin
                        r_valid <= 1'b1;
                    end
                    priority if (!q_ok) begin
                        r_result.queue_count <= '0;
                        unique case (r_req.kind)
                            KIND_ADD:  r_result.result_code <= RC_FULL;
                            KIND_TAKE: r_result.result_code <= RC_EMPTY;
                            default:   r_result.result_code <= RC_LIST_EMPTY;
                        endcase
                    end else if (r_req.kind == KIND_ADD) begin
                        if (full) begin
                            r_result.result_code <= RC_FULL;
                        end else begin
                            r_result.result_code <= RC_ADDED;
                            r_result.queue_count <= 4'(cur_len + LEN_W'(1));
                            r_len[qi]            <= cur_len + LEN_W'(1);
                            if (r_req.urgent) begin
                                r_head[qi] <= slot_dec(cur_head);
                            end
                        end
                    end else if (r_req.kind == KIND_TAKE) begin
                        if (cur_len == '0) begin
                            r_result.result_code <= RC_EMPTY;
                        end else begin
                            r_valid    <= 1'b0;
                            r_cnt      <= cur_len - LEN_W'(1);
                            r_len[qi]  <= cur_len - LEN_W'(1);
                            r_head[qi] <= slot_inc(cur_head);
                            r_state    <= S_TAKE;
                        end
                    end else if (r_req.kind == KIND_LIST) begin
                        if (cur_len == '0) begin
                            r_result.result_code <= RC_LIST_EMPTY;
                        end else begin
                            r_valid <= 1'b0;
                            r_state <= S_LIST;
                        end
                    end else begin
                        r_result.result_code <= RC_EMPTY;
                    end
                end
                S_TAKE: begin
                    r_valid              <= 1'b1;
                    r_result.result_code <= RC_SERVED;
                    r_result.out_tag     <= 16'(ram_rdata[TAG_BITS-1:0]);
                    r_result.out_urgent  <= ram_rdata[TAG_BITS];
                    r_result.queue_count <= 4'(r_cnt);
                    r_result.last        <= 1'b1;
                    r_state              <= S_IDLE;
                end
                S_LIST: begin
                    r_valid              <= 1'b1;
                    r_result.result_code <= RC_LIST_ENTRY;
                    r_result.out_tag     <= 16'(ram_rdata[TAG_BITS-1:0]);
                    r_result.out_urgent  <= ram_rdata[TAG_BITS];
                    r_result.queue_count <= 4'(r_cnt);
                    r_result.last        <= list_last;
                    if (list_last) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_idx  <= r_idx + LEN_W'(1);
                        r_slot <= slot_inc(r_slot);
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

    `TCMQ_ASSERT_RST(a_len_bound, i_clk, i_rst_n,
        (r_state == S_EXEC && q_ok) |-> (32'(cur_len) <= QUEUE_DEPTH),
        "queue length above depth")
    `TCMQ_ASSERT_RST(a_list_burst, i_clk, i_rst_n,
        (o_valid && !o_result.last) |=> o_valid,
        "gap inside a list burst")
    `TCMQ_ASSERT_RST(a_mid_is_list, i_clk, i_rst_n,
        (o_valid && !o_result.last) |-> (o_result.result_code == RC_LIST_ENTRY),
        "non-final result that is not a list entry")
    `TCMQ_ASSERT_RST(a_last_gap, i_clk, i_rst_n,
        (o_valid && o_result.last) |=> !o_valid,
        "result right after the final one")
    `TCMQ_ASSERT_RST(a_busy_cause, i_clk, i_rst_n,
        $rose(busy) |-> $past(start),
        "busy raised without a request")

endmodule

// ===== bench/tb_two_class_multi_queue_core.sv =====
`timescale 1ns / 1ps

module tb_two_class_multi_queue_core;
    import tcmq_pkg::*;

    localparam int RANDOM_REQUESTS = 200;
    localparam int CALM_TAIL       = 40;
    localparam int DRAIN_CYCLES    = 16;

    class queue_bank_tracker;
        logic [15:0] slot_tag [SLOTS];
        logic        slot_urg [SLOTS];
        int          fill_of [NUM_QUEUES];
        t_result     due_results [$];
        int          mismatches;

        function new();
            mismatches = 0;
            foreach (fill_of[q]) fill_of[q] = 0;
        endfunction

        function void queue_result(t_rcode code, logic [15:0] tag, logic urg, int count,
                                   logic last);
            t_result r;
            r.result_code = code;
            r.out_tag     = tag;
            r.out_urgent  = urg;
            r.queue_count = 4'(count);
            r.last        = last;
            due_results.push_back(r);
        endfunction

        function void apply_request(t_req r);
            t_kind       k;
            int          q;
            int          len;
            int          base;
            int          i;
            logic [15:0] head_tag;
            logic        head_urg;
            k = t_kind'(r.kind);
            q = int'(r.queue_id);
            if (k == KIND_NONE) return;
            if (q >= NUM_QUEUES) begin
                case (k)
                    KIND_ADD:  queue_result(RC_FULL, '0, 1'b0, 0, 1'b1);
                    KIND_TAKE: queue_result(RC_EMPTY, '0, 1'b0, 0, 1'b1);
                    default:   queue_result(RC_LIST_EMPTY, '0, 1'b0, 0, 1'b1);
                endcase
                return;
            end
            len  = fill_of[q];
            base = q * QUEUE_DEPTH;
            case (k)
                KIND_ADD: begin
                    if (len >= QUEUE_DEPTH) begin
                        queue_result(RC_FULL, '0, 1'b0, len, 1'b1);
                    end else begin
                        if (r.urgent) begin
                            for (i = len; i > 0; i--) begin
                                slot_tag[base + i] = slot_tag[base + i - 1];
                                slot_urg[base + i] = slot_urg[base + i - 1];
                            end
                            slot_tag[base] = r.tag;
                            slot_urg[base] = 1'b1;
                        end else begin
                            slot_tag[base + len] = r.tag;
                            slot_urg[base + len] = 1'b0;
                        end
                        len++;
                        fill_of[q] = len;
                        queue_result(RC_ADDED, '0, 1'b0, len, 1'b1);
                    end
                end
                KIND_TAKE: begin
                    if (len == 0) begin
                        queue_result(RC_EMPTY, '0, 1'b0, 0, 1'b1);
                    end else begin
                        head_tag = slot_tag[base];
                        head_urg = slot_urg[base];
                        for (i = 0; i + 1 < len; i++) begin
                            slot_tag[base + i] = slot_tag[base + i + 1];
                            slot_urg[base + i] = slot_urg[base + i + 1];
                        end
                        len--;
                        fill_of[q] = len;
                        queue_result(RC_SERVED, head_tag, head_urg, len, 1'b1);
                    end
                end
                default: begin
                    if (len == 0) begin
                        queue_result(RC_LIST_EMPTY, '0, 1'b0, 0, 1'b1);
                    end else begin
                        for (i = 0; i < len; i++) begin
                            queue_result(RC_LIST_ENTRY, slot_tag[base + i], slot_urg[base + i],
                                         len, i == len - 1);
                        end
                    end
                end
            endcase
        endfunction

        function void check_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
                mismatches++;
            end
        endfunction

        function void match_result(t_result got);
            t_result want;
            if (due_results.size() == 0) begin
                $display("%0t: result with none expected, expected nothing, actual %p",
                         $time, got);
                mismatches++;
                return;
            end
            want = due_results.pop_front();
            check_field("result_code", 16'(want.result_code), 16'(got.result_code));
            check_field("out_tag", want.out_tag, got.out_tag);
            check_field("out_urgent", 16'(want.out_urgent), 16'(got.out_urgent));
            check_field("queue_count", 16'(want.queue_count), 16'(got.queue_count));
            check_field("last", 16'(want.last), 16'(got.last));
        endfunction
    endclass

    logic    i_clk;
    logic    i_rst_n;
    logic    start;
    logic    busy;
    t_req    i_req;
    logic    o_valid;
    t_result o_result;

    queue_bank_tracker bank = new();

    two_class_multi_queue_core u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_req    (i_req),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if (o_valid === 1'b1) begin
                bank.match_result(o_result);
            end else if (o_valid !== 1'b0) begin
                $display("%0t: o_valid unknown, expected 0 or 1, actual %b", $time, o_valid);
                bank.mismatches++;
            end
        end
    end

    function automatic t_req make_request(t_kind k, int q, logic [15:0] tag, logic urg);
        t_req r;
        r.kind     = k;
        r.queue_id = 5'(q);
        r.tag      = tag;
        r.urgent   = urg;
        return r;
    endfunction

    // hold start until the request is taken
    task automatic send_request(input t_req r);
        start <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (busy !== 1'b0);
        bank.apply_request(r);
    endtask

    task automatic hold_off(input int cycles);
        start     <= 1'b0;
        i_req.tag <= 16'($urandom);
        repeat (cycles) @(posedge i_clk);
    endtask

    initial begin
        t_req     r;
        int       i;
        int       pick;
        int       counted;
        int       step;
        bit       idling;
        int       hot_a;
        int       hot_b;

        i_rst_n <= 1'b0;
        start   <= 1'b0;
        i_req   <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_request(make_request(KIND_LIST, 0, 16'h0000, 1'b0));
        send_request(make_request(KIND_TAKE, 0, 16'hFFFF, 1'b1));
        send_request(make_request(KIND_ADD, 0, 16'h0000, 1'b0));
        hold_off(3);
        send_request(make_request(KIND_ADD, 0, 16'hFFFF, 1'b0));
        send_request(make_request(KIND_ADD, 0, 16'hA5A5, 1'b1));
        send_request(make_request(KIND_LIST, 0, 16'h0000, 1'b0));
        send_request(make_request(KIND_TAKE, 0, 16'h0000, 1'b0));
        for (i = 0; i < QUEUE_DEPTH; i++) begin
            send_request(make_request(KIND_ADD, NUM_QUEUES - 1, 16'($urandom), i[0]));
        end
        send_request(make_request(KIND_ADD, NUM_QUEUES - 1, 16'hFFFF, 1'b1));
        hold_off(1);
        send_request(make_request(KIND_LIST, NUM_QUEUES - 1, 16'h0000, 1'b0));
        send_request(make_request(KIND_TAKE, NUM_QUEUES - 1, 16'h0000, 1'b0));
        send_request(make_request(KIND_NONE, 5, 16'h1234, 1'b1));
        send_request(make_request(KIND_ADD, NUM_QUEUES - 1, 16'h8001, 1'b0));
        send_request(make_request(KIND_LIST, NUM_QUEUES - 1, 16'h0000, 1'b0));

        counted = 0;
        step    = 0;
        idling  = 1'b0;
        hot_a   = 0;
        hot_b   = 0;
        while (counted < RANDOM_REQUESTS) begin
            if (step % 80 == 0) begin
                hot_a = $urandom_range(0, NUM_QUEUES - 1);
                hot_b = $urandom_range(0, NUM_QUEUES - 1);
            end
            if (step % 20 == 0) idling = ($urandom_range(0, 2) != 0);
            pick = $urandom_range(0, 99);
            if (pick < 50)      r.kind = KIND_ADD;
            else if (pick < 75) r.kind = KIND_TAKE;
            else if (pick < 95) r.kind = KIND_LIST;
            else                r.kind = KIND_NONE;
            if ($urandom_range(0, 99) < 85)
                r.queue_id = 5'($urandom_range(0, 1) ? hot_a : hot_b);
            else
                r.queue_id = 5'($urandom_range(0, NUM_QUEUES - 1));
            r.tag    = 16'($urandom);
            r.urgent = 1'($urandom);
            if (t_kind'(r.kind) != KIND_NONE) counted++;
            send_request(r);
            if (idling && counted < RANDOM_REQUESTS - CALM_TAIL && $urandom_range(0, 2) == 0)
                hold_off($urandom_range(1, 12));
            step++;
        end
        start <= 1'b0;

        while (bank.due_results.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (bank.mismatches == 0 && bank.due_results.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== two_class_multi_queue_core.f =====
+incdir+design
design/tcmq_pkg.sv
design/tcmq_ram.sv
design/two_class_multi_queue_core.sv
bench/tb_two_class_multi_queue_core.sv
